// ===== sv/assert_macros.svh =====
// Assertion macros shared by the trace ring buffer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_HOLDS(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`else

`define ASSERT_HOLDS(lbl, clk, rst_n, expr, msg)

`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== sv/trb_pkg.sv =====
// Types, constants and request codes of the trace ring buffer.
package trb_pkg;

    localparam int DEPTH         = 1024;
    localparam int CYCLES_PER_MS = 480000;
    localparam int EVENT_KINDS   = 19;

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int PTR_W  = ADDR_W + 1;

    localparam int MS_W   = 14;
    localparam int US_W   = 10;
    localparam int MS_MAX = 16383;
    localparam int US_MAX = 999;

    localparam int US_DIV = (CYCLES_PER_MS / 1000 == 0) ? 1 : CYCLES_PER_MS / 1000;

    // Reciprocal constants: a multiply by MUL and a right shift by SH give the exact
    // quotient over the whole operand range, since the rounding error of MUL times the
    // largest operand stays below one step of the shift.
    localparam int MS_SH     = 32 + $clog2(CYCLES_PER_MS);
    localparam int MS_MUL_W  = 34;
    localparam logic [MS_MUL_W-1:0] MS_MUL =
        MS_MUL_W'(((64'd1 << MS_SH) + 64'(CYCLES_PER_MS) - 64'd1) / 64'(CYCLES_PER_MS));
    localparam int MS_PROD_W = MS_MUL_W + 16;
    localparam int MS_SUM_W  = MS_MUL_W + 32;
    localparam logic [31:0] CYCLES_PER_MS_W = 32'(CYCLES_PER_MS);

    localparam int REM_W     = $clog2(CYCLES_PER_MS);
    localparam int US_SH     = REM_W + $clog2(US_DIV);
    localparam int US_MUL_W  = REM_W + 2;
    localparam logic [US_MUL_W-1:0] US_MUL =
        US_MUL_W'(((64'd1 << US_SH) + 64'(US_DIV) - 64'd1) / 64'(US_DIV));
    localparam int US_PROD_W = REM_W + US_MUL_W;

    localparam logic [1:0] REQ_RECORD = 2'd0;
    localparam logic [1:0] REQ_DRAIN  = 2'd1;
    localparam logic [1:0] REQ_REPORT = 2'd2;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  event_code;
        logic [31:0] handle_value;
        logic [31:0] task_tag;
        logic [31:0] stamp;
    } in_t;

    typedef struct packed {
        logic            recorded;
        logic            discarded;
        logic            entry_valid;
        logic [7:0]      entry_event;
        logic            entry_known;
        logic [31:0]     entry_handle;
        logic            entry_has_handle;
        logic [31:0]     entry_task;
        logic [MS_W-1:0] entry_ms;
        logic [US_W-1:0] entry_us;
        logic [31:0]     lost_count;
    } out_t;

    typedef struct packed {
        logic [31:0] stamp;
        logic [31:0] handle_value;
        logic [31:0] task_tag;
        logic [7:0]  event_code;
    } rec_t;

    typedef struct packed {
        logic            done;
        logic [MS_W-1:0] ms;
        logic [US_W-1:0] us;
    } div_res_t;

endpackage

// ===== sv/trb_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module trb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/trb_div.sv =====
// Constant divider by reciprocal multiplication: splits a stamp into milliseconds and microseconds.
module trb_div (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [31:0]         stamp,
    output trb_pkg::div_res_t   res
);

    logic [31:0]                   stamp_reg, stamp_next;
    logic [trb_pkg::MS_PROD_W-1:0] lo_prod_reg, lo_prod_next;
    logic [trb_pkg::MS_PROD_W-1:0] hi_prod_reg, hi_prod_next;
    logic [31:0]                   quo_reg, quo_next;
    logic [trb_pkg::REM_W-1:0]     rem_reg, rem_next;
    logic [trb_pkg::MS_W-1:0]      ms_reg, ms_next;
    logic [trb_pkg::US_W-1:0]      us_reg, us_next;
    logic                          prod_vld_reg;
    logic                          quo_vld_reg;
    logic                          rem_vld_reg;
    logic                          done_reg;

    logic [trb_pkg::MS_SUM_W-1:0]  ms_sum;
    logic [31:0]                   rem_full;
    logic [trb_pkg::US_PROD_W-1:0] us_prod;
    logic [trb_pkg::US_PROD_W-1:0] us_quo;

    // The stamp is multiplied in two halves so that neither product is wider than 16 by 34.
    always_comb
    begin
        ms_sum   = {hi_prod_reg, 16'h0000} + trb_pkg::MS_SUM_W'(lo_prod_reg);
        rem_full = stamp_reg - quo_reg * trb_pkg::CYCLES_PER_MS_W;
        us_prod  = trb_pkg::US_PROD_W'(rem_reg) * trb_pkg::US_PROD_W'(trb_pkg::US_MUL);
        us_quo   = us_prod >> trb_pkg::US_SH;
    end

    always_comb
    begin
        stamp_next   = stamp_reg;
        lo_prod_next = lo_prod_reg;
        hi_prod_next = hi_prod_reg;
        quo_next     = quo_reg;
        rem_next     = rem_reg;
        ms_next      = ms_reg;
        us_next      = us_reg;

        if (start)
        begin
            stamp_next   = stamp;
            lo_prod_next = trb_pkg::MS_PROD_W'(stamp[15:0])
                           * trb_pkg::MS_PROD_W'(trb_pkg::MS_MUL);
            hi_prod_next = trb_pkg::MS_PROD_W'(stamp[31:16])
                           * trb_pkg::MS_PROD_W'(trb_pkg::MS_MUL);
        end
        if (prod_vld_reg)
        begin
            quo_next = 32'(ms_sum >> trb_pkg::MS_SH);
        end
        if (quo_vld_reg)
        begin
            // The remainder is below the divisor, so its upper bits are zero.
            rem_next = rem_full[trb_pkg::REM_W-1:0];
            if (quo_reg > 32'(trb_pkg::MS_MAX))
            begin
                ms_next = trb_pkg::MS_W'(trb_pkg::MS_MAX);
            end
            else
            begin
                ms_next = quo_reg[trb_pkg::MS_W-1:0];
            end
        end
        if (rem_vld_reg)
        begin
            if (us_quo > trb_pkg::US_PROD_W'(trb_pkg::US_MAX))
            begin
                us_next = trb_pkg::US_W'(trb_pkg::US_MAX);
            end
            else
            begin
                us_next = us_quo[trb_pkg::US_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stamp_reg    <= '0;
            lo_prod_reg  <= '0;
            hi_prod_reg  <= '0;
            quo_reg      <= '0;
            rem_reg      <= '0;
            ms_reg       <= '0;
            us_reg       <= '0;
            prod_vld_reg <= 1'b0;
            quo_vld_reg  <= 1'b0;
            rem_vld_reg  <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            stamp_reg    <= stamp_next;
            lo_prod_reg  <= lo_prod_next;
            hi_prod_reg  <= hi_prod_next;
            quo_reg      <= quo_next;
            rem_reg      <= rem_next;
            ms_reg       <= ms_next;
            us_reg       <= us_next;
            prod_vld_reg <= start;
            quo_vld_reg  <= prod_vld_reg;
            rem_vld_reg  <= quo_vld_reg;
            done_reg     <= rem_vld_reg;
        end
    end

    assign res.done = done_reg;
    assign res.ms   = ms_reg;
    assign res.us   = us_reg;

endmodule

// ===== sv/trace_event_ring_buffer_core.sv =====
// Top level of the trace event ring buffer: ring control, record memory and divider.
//
// Request channel (req_valid, req_stall, req_data) carries one request per beat:
// record an event, drain the oldest record, or read the drop report. Every request
// gives exactly one beat on the response channel (rsp_valid, rsp_stall, rsp_data).
// Records, drop reports and drains of an empty ring answer on the edge after
// acceptance if the output register is free, and they can be accepted one per
// cycle while the response side keeps up. A drain that returns a record reads the
// ring memory, splits the stamp by reciprocal multiplication in pipelined steps
// (half products, quotient, remainder and milliseconds, microseconds) and passes
// the pending register; the next request is taken once its response is registered.
// A full ring discards new records and counts them; the count is returned and
// cleared by a drop report.
// Reset empties the ring and clears the drop count; there is no clearing pass.
// When the receiver stalls, the response waits in the output register; one more
// request can be accepted and its response held, after which req_stall rises.
`include "assert_macros.svh"

module trace_event_ring_buffer_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  trb_pkg::in_t  req_data,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output trb_pkg::out_t rsp_data
);

    typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_DIV, ST_PUSH} state_t;

    state_t                       state_reg, state_next;
    logic [trb_pkg::PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [trb_pkg::PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [31:0]                  lost_reg, lost_next;
    trb_pkg::out_t                pend_reg, pend_next;
    trb_pkg::out_t                rsp_data_reg, rsp_data_next;
    logic                         rsp_valid_reg, rsp_valid_next;

    logic                         accept;
    logic                         out_free;
    logic                         full;
    logic                         empty;
    logic [trb_pkg::PTR_W-1:0]    occupancy;
    trb_pkg::out_t                imm_res;
    logic                         mem_wr_en;
    logic                         mem_rd_en;
    logic [$bits(trb_pkg::rec_t)-1:0] mem_rd_data;
    trb_pkg::rec_t                wr_rec;
    trb_pkg::rec_t                rd_rec;
    logic                         div_start;
    trb_pkg::div_res_t            div_res;

    assign req_stall = (state_reg != ST_IDLE);
    assign accept    = req_valid && !req_stall;
    assign out_free  = !rsp_valid_reg || !rsp_stall;

    // The pointers carry one extra bit so that a full ring differs from an empty one.
    assign occupancy = wr_ptr_reg - rd_ptr_reg;
    assign empty     = (wr_ptr_reg == rd_ptr_reg);
    assign full      = (wr_ptr_reg[trb_pkg::ADDR_W] != rd_ptr_reg[trb_pkg::ADDR_W])
                       && (wr_ptr_reg[trb_pkg::ADDR_W-1:0] == rd_ptr_reg[trb_pkg::ADDR_W-1:0]);

    assign mem_wr_en = accept && (req_data.req_type == trb_pkg::REQ_RECORD) && !full;
    assign mem_rd_en = accept && (req_data.req_type == trb_pkg::REQ_DRAIN) && !empty;

    always_comb
    begin
        wr_rec.stamp        = req_data.stamp;
        wr_rec.handle_value = req_data.handle_value;
        wr_rec.task_tag     = req_data.task_tag;
        wr_rec.event_code   = req_data.event_code;
    end

    assign rd_rec    = trb_pkg::rec_t'(mem_rd_data);
    assign div_start = (state_reg == ST_READ);

    trb_ram #(
        .WIDTH ($bits(trb_pkg::rec_t)),
        .DEPTH (trb_pkg::DEPTH)
    ) u_ring (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (wr_ptr_reg[trb_pkg::ADDR_W-1:0]),
        .wr_data (wr_rec),
        .rd_en   (mem_rd_en),
        .rd_addr (rd_ptr_reg[trb_pkg::ADDR_W-1:0]),
        .rd_data (mem_rd_data)
    );

    trb_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .stamp (rd_rec.stamp),
        .res   (div_res)
    );

    // Responses that need no memory access; a drain of an empty ring is all zero.
    always_comb
    begin
        imm_res = '0;
        case (req_data.req_type)
            trb_pkg::REQ_RECORD:
            begin
                imm_res.recorded  = !full;
                imm_res.discarded = full;
            end
            trb_pkg::REQ_REPORT:
            begin
                imm_res.lost_count = lost_reg;
            end
            default:
            begin
                imm_res = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        wr_ptr_next    = wr_ptr_reg;
        rd_ptr_next    = rd_ptr_reg;
        lost_next      = lost_reg;
        pend_next      = pend_reg;
        rsp_data_next  = rsp_data_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (req_data.req_type)
                        trb_pkg::REQ_RECORD:
                        begin
                            if (full)
                            begin
                                lost_next = lost_reg + 32'd1;
                            end
                            else
                            begin
                                wr_ptr_next = wr_ptr_reg + 1'b1;
                            end
                        end
                        trb_pkg::REQ_DRAIN:
                        begin
                            if (!empty)
                            begin
                                rd_ptr_next = rd_ptr_reg + 1'b1;
                            end
                        end
                        trb_pkg::REQ_REPORT:
                        begin
                            lost_next = '0;
                        end
                        default:
                        begin
                            lost_next = lost_reg;
                        end
                    endcase

                    if (mem_rd_en)
                    begin
                        state_next = ST_READ;
                    end
                    else if (out_free)
                    begin
                        rsp_data_next  = imm_res;
                        rsp_valid_next = 1'b1;
                    end
                    else
                    begin
                        pend_next  = imm_res;
                        state_next = ST_PUSH;
                    end
                end
            end
            ST_READ:
            begin
                pend_next                  = '0;
                pend_next.entry_valid      = 1'b1;
                pend_next.entry_event      = rd_rec.event_code;
                pend_next.entry_known      = ({1'b0, rd_rec.event_code}
                                              < 9'(trb_pkg::EVENT_KINDS));
                pend_next.entry_handle     = rd_rec.handle_value;
                pend_next.entry_has_handle = (rd_rec.handle_value != '0);
                pend_next.entry_task       = rd_rec.task_tag;
                state_next                 = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_res.done)
                begin
                    pend_next.entry_ms = div_res.ms;
                    pend_next.entry_us = div_res.us;
                    state_next         = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                if (out_free)
                begin
                    rsp_data_next  = pend_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wr_ptr_reg    <= '0;
            rd_ptr_reg    <= '0;
            lost_reg      <= '0;
            pend_reg      <= '0;
            rsp_data_reg  <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wr_ptr_reg    <= wr_ptr_next;
            rd_ptr_reg    <= rd_ptr_next;
            lost_reg      <= lost_next;
            pend_reg      <= pend_next;
            rsp_data_reg  <= rsp_data_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    `ASSERT_HOLDS(a_occupancy_bound, clk, rst_n, occupancy <= trb_pkg::PTR_W'(trb_pkg::DEPTH), "ring holds more records than its depth")

    `ASSERT_IMPLIES(a_div_done_in_div, clk, rst_n, div_res.done, state_reg == ST_DIV, "divider finished while no drain was waiting")

    `ASSERT_IMPLIES(a_read_before_div, clk, rst_n, state_reg == ST_READ, $past(mem_rd_en), "record read state without a memory read")

    `ASSERT_IMPLIES(a_us_range, clk, rst_n, rsp_valid_reg, rsp_data_reg.entry_us <= trb_pkg::US_W'(trb_pkg::US_MAX), "microsecond field out of range")

endmodule

// ===== sim/tb_trace_event_ring_buffer_core.sv =====
// Self-checking testbench for the trace event ring buffer: directed table, then random traffic.
module tb_trace_event_ring_buffer_core;

    localparam logic [1:0]  REQ_UNUSED = 2'd3;
    localparam logic [31:0] CYC_MS     = (trb_pkg::CYCLES_PER_MS == 0) ? 32'd1
                                                                        : 32'(trb_pkg::CYCLES_PER_MS);
    localparam logic [31:0] CYC_US     = (CYC_MS / 1000 == 0) ? 32'd1 : CYC_MS / 1000;
    localparam logic [31:0] MS_CAP     = trb_pkg::MS_MAX;
    localparam logic [31:0] US_CAP     = trb_pkg::US_MAX;
    localparam logic [31:0] RING_SLOTS = trb_pkg::DEPTH;
    localparam int          MIXED_ITEMS = 650;
    localparam int          FILL_ITEMS  = 1080;
    localparam int          LONG_HOLD   = 400;
    localparam int          SETTLE      = 40;

    typedef enum {MIX_BALANCED, MIX_DRAIN, MIX_RECORD, MIX_FILL} mix_t;
    typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

    typedef struct {
        trb_pkg::in_t  rq;
        bit            typed;
        trb_pkg::out_t want;
    } row_t;

    logic          clk;
    logic          rst_n;
    logic          req_valid;
    logic          req_stall;
    trb_pkg::in_t  req_data;
    logic          rsp_valid;
    logic          rsp_stall;
    trb_pkg::out_t rsp_data;

    // Predictor copy of the ring and its counters.
    logic [31:0] ring_stamp  [trb_pkg::DEPTH];
    logic [31:0] ring_handle [trb_pkg::DEPTH];
    logic [31:0] ring_task   [trb_pkg::DEPTH];
    logic [7:0]  ring_event  [trb_pkg::DEPTH];
    logic [31:0] ring_wr;
    logic [31:0] ring_rd;
    logic [31:0] drops_total;
    logic [31:0] drops_reported;

    trb_pkg::out_t ring_answers_due [$];
    row_t          directed_rows [$];

    int unsigned mismatches;
    int unsigned burst_left;
    bit          hold_wanted;
    int unsigned n_recorded, n_discarded, n_drained, n_empty_drains, n_reports, n_unused;
    logic [31:0] peak_fill;

    trace_event_ring_buffer_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_data  (rsp_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic trb_pkg::out_t ring_answer(trb_pkg::in_t rq);
        trb_pkg::out_t               ans;
        logic [trb_pkg::ADDR_W-1:0]  slot;
        logic [31:0]                 ts;
        logic [31:0]                 ms_q;
        logic [31:0]                 us_q;
        ans = '0;
        case (rq.req_type)
            trb_pkg::REQ_RECORD:
            begin
                if (ring_wr - ring_rd >= RING_SLOTS)
                begin
                    drops_total = drops_total + 32'd1;
                    ans.discarded = 1'b1;
                    n_discarded++;
                end
                else
                begin
                    slot = ring_wr[trb_pkg::ADDR_W-1:0];
                    ring_stamp[slot]  = rq.stamp;
                    ring_handle[slot] = rq.handle_value;
                    ring_task[slot]   = rq.task_tag;
                    ring_event[slot]  = rq.event_code;
                    ring_wr = ring_wr + 32'd1;
                    ans.recorded = 1'b1;
                    n_recorded++;
                    if (ring_wr - ring_rd > peak_fill)
                        peak_fill = ring_wr - ring_rd;
                end
            end
            trb_pkg::REQ_DRAIN:
            begin
                if (ring_rd == ring_wr)
                    n_empty_drains++;
                else
                begin
                    slot = ring_rd[trb_pkg::ADDR_W-1:0];
                    ts   = ring_stamp[slot];
                    ms_q = ts / CYC_MS;
                    us_q = (ts % CYC_MS) / CYC_US;
                    ring_rd = ring_rd + 32'd1;
                    ans.entry_valid      = 1'b1;
                    ans.entry_event      = ring_event[slot];
                    ans.entry_known      = (32'(ring_event[slot]) < 32'(trb_pkg::EVENT_KINDS));
                    ans.entry_handle     = ring_handle[slot];
                    ans.entry_has_handle = (ring_handle[slot] != 32'd0);
                    ans.entry_task       = ring_task[slot];
                    ans.entry_ms = (ms_q > MS_CAP) ? MS_CAP[trb_pkg::MS_W-1:0]
                                                   : ms_q[trb_pkg::MS_W-1:0];
                    ans.entry_us = (us_q > US_CAP) ? US_CAP[trb_pkg::US_W-1:0]
                                                   : us_q[trb_pkg::US_W-1:0];
                    n_drained++;
                end
            end
            trb_pkg::REQ_REPORT:
            begin
                ans.lost_count = drops_total - drops_reported;
                drops_reported = drops_total;
                n_reports++;
            end
            default:
                n_unused++;
        endcase
        return ans;
    endfunction

    function automatic trb_pkg::in_t random_request(mix_t mix);
        trb_pkg::in_t    rq;
        int unsigned     pick;
        int unsigned     rec_cut;
        int unsigned     drain_cut;
        int unsigned     report_cut;
        longint unsigned near_stamp;
        case (mix)
            MIX_FILL:     begin rec_cut = 97; drain_cut = 98; report_cut = 99; end
            MIX_DRAIN:    begin rec_cut = 20; drain_cut = 85; report_cut = 97; end
            MIX_RECORD:   begin rec_cut = 70; drain_cut = 88; report_cut = 97; end
            default:      begin rec_cut = 45; drain_cut = 85; report_cut = 96; end
        endcase
        pick = $urandom_range(0, 99);
        if (pick < rec_cut)
            rq.req_type = trb_pkg::REQ_RECORD;
        else if (pick < drain_cut)
            rq.req_type = trb_pkg::REQ_DRAIN;
        else if (pick < report_cut)
            rq.req_type = trb_pkg::REQ_REPORT;
        else
            rq.req_type = REQ_UNUSED;
        // Half the codes are drawn from the known kinds so both outcomes are common.
        rq.event_code = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, trb_pkg::EVENT_KINDS - 1))
                                                    : 8'($urandom_range(0, 255));
        case ($urandom_range(0, 7))
            0:       rq.handle_value = '0;
            1:       rq.handle_value = '1;
            default: rq.handle_value = $urandom;
        endcase
        if ($urandom_range(0, 15) == 0)
            rq.task_tag = ($urandom_range(0, 1) == 0) ? '0 : '1;
        else
            rq.task_tag = $urandom;
        case ($urandom_range(0, 7))
            0: rq.stamp = ($urandom_range(0, 1) == 0) ? '0 : '1;
            1:
            begin
                // Land on or just beside a millisecond boundary.
                near_stamp = longint'($urandom_range(0, 8947)) * CYC_MS
                             + (($urandom_range(0, 1) == 0) ? CYC_MS - 1
                                                            : $urandom_range(0, 2 * CYC_US));
                rq.stamp = near_stamp[31:0];
            end
            default: rq.stamp = $urandom;
        endcase
        return rq;
    endfunction

    function automatic void add_row(trb_pkg::in_t rq, bit typed, trb_pkg::out_t want);
        row_t r;
        r.rq    = rq;
        r.typed = typed;
        r.want  = want;
        directed_rows.push_back(r);
    endfunction

    task automatic pace_sender();
        int unsigned gap;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            gap = $urandom_range(0, 8);
            if (gap != 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
        end
    endtask

    task automatic offer_request(trb_pkg::in_t rq, bit typed, trb_pkg::out_t want);
        trb_pkg::out_t ans;
        req_valid <= 1'b1;
        req_data  <= rq;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        ans = ring_answer(rq);
        ring_answers_due.push_back(typed ? want : ans);
        pace_sender();
    endtask

    task automatic pause_until_answered();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (ring_answers_due.size() != 0);
    endtask

    task automatic compare_field(string field, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("Mismatch on %s: expected 0x%0h, got 0x%0h", field, want, got);
        end
    endtask

    task automatic check_reply(trb_pkg::out_t got);
        trb_pkg::out_t want;
        if (ring_answers_due.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("Unexpected reply beat: 0x%0h", got);
        end
        else
        begin
            want = ring_answers_due.pop_front();
            compare_field("recorded", 32'(want.recorded), 32'(got.recorded));
            compare_field("discarded", 32'(want.discarded), 32'(got.discarded));
            compare_field("entry_valid", 32'(want.entry_valid), 32'(got.entry_valid));
            compare_field("entry_event", 32'(want.entry_event), 32'(got.entry_event));
            compare_field("entry_known", 32'(want.entry_known), 32'(got.entry_known));
            compare_field("entry_handle", want.entry_handle, got.entry_handle);
            compare_field("entry_has_handle", 32'(want.entry_has_handle),
                          32'(got.entry_has_handle));
            compare_field("entry_task", want.entry_task, got.entry_task);
            compare_field("entry_ms", 32'(want.entry_ms), 32'(got.entry_ms));
            compare_field("entry_us", 32'(want.entry_us), 32'(got.entry_us));
            compare_field("lost_count", want.lost_count, got.lost_count);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            check_reply(rsp_data);
    end

    // Reply side: stall patterns that change now and then, plus one long hold on request.
    initial
    begin
        stall_mode_t mode;
        int unsigned mode_left;
        int unsigned hold_left;
        int unsigned tick;
        rsp_stall = 1'b0;
        mode      = STALL_NONE;
        mode_left = 0;
        hold_left = 0;
        tick      = 0;
        forever
        begin
            @(posedge clk);
            tick++;
            if (hold_wanted)
            begin
                hold_wanted = 1'b0;
                hold_left   = LONG_HOLD;
            end
            if (mode_left == 0)
            begin
                mode      = stall_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(30, 300);
            end
            mode_left--;
            if (hold_left != 0)
            begin
                hold_left--;
                rsp_stall <= 1'b1;
            end
            else
            begin
                case (mode)
                    STALL_LIGHT:    rsp_stall <= ($urandom_range(0, 3) == 0);
                    STALL_HEAVY:    rsp_stall <= ($urandom_range(0, 3) != 0);
                    STALL_PERIODIC: rsp_stall <= (tick % 7 < 3);
                    default:        rsp_stall <= 1'b0;
                endcase
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("Timed out waiting for the block");
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        trb_pkg::out_t ans_none;
        trb_pkg::out_t ans_rec;
        trb_pkg::in_t  zero_rq;
        int unsigned   sent;
        int unsigned   seg_len;
        int unsigned   k;
        mix_t          mix;

        clk            = 1'b0;
        rst_n          = 1'b0;
        req_valid      = 1'b0;
        req_data       = '0;
        hold_wanted    = 1'b0;
        mismatches     = 0;
        burst_left     = 0;
        ring_wr        = '0;
        ring_rd        = '0;
        drops_total    = '0;
        drops_reported = '0;
        peak_fill      = '0;
        n_recorded     = 0;
        n_discarded    = 0;
        n_drained      = 0;
        n_empty_drains = 0;
        n_reports      = 0;
        n_unused       = 0;
        zero_rq        = '0;

        ans_none = '0;
        ans_rec  = '0;
        ans_rec.recorded = 1'b1;

        add_row({trb_pkg::REQ_DRAIN, 8'h00, 32'h0, 32'h0, 32'h0}, 1'b1, ans_none);
        add_row({trb_pkg::REQ_REPORT, 8'h00, 32'h0, 32'h0, 32'h0}, 1'b1, ans_none);
        add_row({REQ_UNUSED, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
                1'b1, ans_none);
        add_row({trb_pkg::REQ_RECORD, 8'h00, 32'h0, 32'h0, 32'h0}, 1'b1, ans_rec);
        add_row({trb_pkg::REQ_RECORD, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
                1'b1, ans_rec);
        add_row({trb_pkg::REQ_RECORD, 8'd18, 32'h1, 32'h5A5A_5A5A, 32'd479999}, 1'b1, ans_rec);
        add_row({trb_pkg::REQ_RECORD, 8'd19, 32'h8000_0000, 32'h1, 32'd480000}, 1'b1, ans_rec);
        add_row({trb_pkg::REQ_RECORD, 8'd7, 32'h0, 32'hA5A5_A5A5, 32'd479}, 1'b1, ans_rec);
        add_row({trb_pkg::REQ_RECORD, 8'd8, 32'h2, 32'h7FFF_FFFF, 32'd480}, 1'b1, ans_rec);
        add_row({trb_pkg::REQ_REPORT, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
                1'b1, ans_none);
        add_row({trb_pkg::REQ_DRAIN, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF},
                1'b0, ans_none);
        for (k = 0; k < 5; k++)
            add_row({trb_pkg::REQ_DRAIN, 8'h00, 32'h0, 32'h0, 32'h0}, 1'b0, ans_none);
        add_row({trb_pkg::REQ_DRAIN, 8'h00, 32'h0, 32'h0, 32'h0}, 1'b1, ans_none);
        add_row({REQ_UNUSED, 8'h00, 32'h0, 32'h0, 32'h0}, 1'b1, ans_none);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            offer_request(directed_rows[i].rq, directed_rows[i].typed, directed_rows[i].want);
        pause_until_answered();

        // Mixed traffic keeps the ring shallow, so empty drains and reports interleave.
        sent = 0;
        while (sent < MIXED_ITEMS)
        begin
            mix     = mix_t'($urandom_range(0, 2));
            seg_len = $urandom_range(40, 120);
            for (k = 0; k < seg_len; k++)
                offer_request(random_request(mix), 1'b0, zero_rq);
            sent += seg_len;
            pause_until_answered();
        end

        // Fill past capacity while the reply side holds off for a long stretch.
        hold_wanted = 1'b1;
        for (k = 0; k < FILL_ITEMS; k++)
            offer_request(random_request(MIX_FILL), 1'b0, zero_rq);
        req_valid <= 1'b0;

        for (k = 0; k < 100000 && ring_answers_due.size() != 0; k++)
            @(posedge clk);
        if (ring_answers_due.size() != 0)
        begin
            mismatches += ring_answers_due.size();
            $display("%0d expected reply beats never arrived", ring_answers_due.size());
        end
        repeat (SETTLE) @(posedge clk);

        $display("Covered %0d records (%0d discarded at a full ring), %0d drains (%0d empty),",
                 n_recorded, n_discarded, n_drained + n_empty_drains, n_empty_drains);
        $display("%0d drop reports, %0d unused selectors; peak ring fill %0d of %0d.",
                 n_reports, n_unused, peak_fill, trb_pkg::DEPTH);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
